>>> rtl/fjr_pkg.sv
// Shared types and constants for the feeder jam recovery controller.
`timescale 1ns / 1ps

package fjr_pkg;

  // Widths of the stream words
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [15:0] TicksMax = 16'hFFFF;

  // Jam supervisor phases
  typedef enum logic [1:0] {
    PH_NORMAL  = 2'd0,
    PH_SUSPECT = 2'd1,
    PH_CONFIRM = 2'd2,
    PH_RECOVER = 2'd3
  } phase_e;

  // Fire modes
  typedef enum logic [1:0] {
    FM_DISABLE = 2'd0,
    FM_CEASE   = 2'd1,
    FM_SINGLE  = 2'd2,
    FM_AUTO    = 2'd3
  } fire_mode_e;

  // Feeder command kinds
  typedef enum logic [1:0] {
    DRV_OFF   = 2'd0,
    DRV_ANGLE = 2'd1,
    DRV_SPEED = 2'd2
  } drive_e;

  // Register indexes on the config port
  typedef enum logic [CfgAddrW-1:0] {
    REG_TORQUE_TH  = 3'd0,
    REG_SPEED_TH   = 3'd1,
    REG_SUSPECT    = 3'd2,
    REG_RECOVER    = 3'd3,
    REG_BACKOFF    = 3'd4,
    REG_BULLET     = 3'd5,
    REG_HEAT_SHOT  = 3'd6,
    REG_AUTO_RATE  = 3'd7
  } cfg_addr_e;

  // Configuration register file contents
  typedef struct packed {
    logic [14:0]        torque_threshold;
    logic [15:0]        speed_threshold;
    logic [15:0]        suspect_ticks;
    logic [15:0]        recover_ticks;
    logic signed [31:0] backoff_step;
    logic signed [31:0] bullet_step;
    logic [15:0]        heat_per_shot;
    logic [7:0]         auto_rate;
  } cfg_t;

  // One control tick
  typedef struct packed {
    logic signed [15:0] measured_torque;
    logic signed [16:0] measured_speed;
    logic signed [31:0] measured_angle;
    logic [15:0]        heat_limit;
    logic [15:0]        heat_now;
    logic               mode_write;
    logic [1:0]         mode_value;
  } in_item_t;

  // One feeder command
  typedef struct packed {
    drive_e             drive_mode;
    logic signed [31:0] target_angle;
    logic signed [31:0] target_speed;
    logic [7:0]         shot_rate_now;
    phase_e             jam_state;
    logic               heat_ok;
    logic               clear_integrators;
  } out_item_t;

endpackage

>>> rtl/feeder_jam_recovery_controller.sv
// Top level of the feeder jam recovery controller.
//
// One word on the slave stream is one control tick of the feeder: torque,
// speed, continuous angle, heat readings and an optional new fire mode.
// Each tick gives exactly one command word on the master stream: drive kind,
// target angle and speed, shot rate, jam state, heat flag and an integrator
// clear request. Registers are written over the cfg channel (always ready);
// write them only while no tick is in flight, the block does not enforce it.
//
// From acceptance to the command showing on m_axis, the tick lands in the
// input register, then the jam and fire logic runs combinationally into the
// output register, updating the held state at the same clock edge.
// Throughput is one tick per cycle while m_axis does not stall, bounded by
// that single compute stage with its 32x9 multiply.
//
// Reset clears the registers to 0, the jam state to normal, fire mode to
// ceasefire and the held command to an angle hold at 0. When m_axis stalls,
// the output word holds, one more tick is buffered in the input register,
// and then s_axis_tready drops until the receiver takes the word.
`timescale 1ns / 1ps

module feeder_jam_recovery_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tick in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // measured_torque, measured_speed, measured_angle, heat_limit, heat_now,
  // mode_write, mode_value, zero pad
  input  logic [fjr_pkg::InDataW-1:0]   s_axis_tdata,
  // command out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // drive_mode, target_angle, target_speed, shot_rate_now, jam_state,
  // heat_ok, clear_integrators, zero pad
  output logic [fjr_pkg::OutDataW-1:0]  m_axis_tdata,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fjr_pkg::CfgAddrW-1:0]  cfg_index_i,
  input  logic [fjr_pkg::CfgDataW-1:0]  cfg_data_i
);

  fjr_pkg::cfg_t      cfg;
  fjr_pkg::in_item_t  in_word;
  fjr_pkg::in_item_t  in_data_q;
  logic               in_valid_q;
  fjr_pkg::out_item_t res;
  fjr_pkg::out_item_t out_data_q;
  logic               out_valid_q;
  logic               advance;
  logic               step;

  assign cfg_ready_o = 1'b1;

  fjr_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_addr_i (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // Unpack the tick word, first field at bit 0
  always_comb begin
    in_word.measured_torque = s_axis_tdata[15:0];
    in_word.measured_speed  = s_axis_tdata[32:16];
    in_word.measured_angle  = s_axis_tdata[64:33];
    in_word.heat_limit      = s_axis_tdata[80:65];
    in_word.heat_now        = s_axis_tdata[96:81];
    in_word.mode_write      = s_axis_tdata[97];
    in_word.mode_value      = s_axis_tdata[99:98];
  end

  // Pipeline flow control
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = advance && in_valid_q;
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= in_word;
    end
  end

  fjr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .item_i (in_data_q),
    .res_o  (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00,
                          out_data_q.clear_integrators,
                          out_data_q.heat_ok,
                          out_data_q.jam_state,
                          out_data_q.shot_rate_now,
                          out_data_q.target_speed,
                          out_data_q.target_angle,
                          out_data_q.drive_mode};

  // An empty output stage never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // Integrator clear only comes with the disabled drive
  a_clear_means_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.clear_integrators |->
      out_data_q.drive_mode == fjr_pkg::DRV_OFF)
    else $error("integrator clear without disabled drive");

  // Fire mode is not applied during a confirmed jam
  a_no_fire_in_jam: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q.jam_state == fjr_pkg::PH_CONFIRM ||
                    out_data_q.jam_state == fjr_pkg::PH_RECOVER) |->
      !out_data_q.clear_integrators)
    else $error("fire mode applied during jam handling");

  // A tick moved into the output register shows up as valid next cycle
  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("computed word lost");

endmodule

>>> rtl/fjr_cfg_regs.sv
// Configuration register file of the feeder jam recovery controller.
`timescale 1ns / 1ps

module fjr_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [fjr_pkg::CfgAddrW-1:0]   wr_addr_i,
  input  logic [fjr_pkg::CfgDataW-1:0]   wr_data_i,
  output fjr_pkg::cfg_t                  cfg_o
);

  fjr_pkg::cfg_t cfg_q, cfg_d;

  // Address decode, each register keeps its own low bits
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (fjr_pkg::cfg_addr_e'(wr_addr_i))
        fjr_pkg::REG_TORQUE_TH: cfg_d.torque_threshold = wr_data_i[14:0];
        fjr_pkg::REG_SPEED_TH:  cfg_d.speed_threshold  = wr_data_i[15:0];
        fjr_pkg::REG_SUSPECT:   cfg_d.suspect_ticks    = wr_data_i[15:0];
        fjr_pkg::REG_RECOVER:   cfg_d.recover_ticks    = wr_data_i[15:0];
        fjr_pkg::REG_BACKOFF:   cfg_d.backoff_step     = wr_data_i[31:0];
        fjr_pkg::REG_BULLET:    cfg_d.bullet_step      = wr_data_i[31:0];
        fjr_pkg::REG_HEAT_SHOT: cfg_d.heat_per_shot    = wr_data_i[15:0];
        fjr_pkg::REG_AUTO_RATE: cfg_d.auto_rate        = wr_data_i[7:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/fjr_core.sv
// Jam state machine, fire mode logic and held feeder command of the controller.
`timescale 1ns / 1ps

module fjr_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fjr_pkg::cfg_t        cfg_i,
  input  logic                 step_i,
  input  fjr_pkg::in_item_t    item_i,
  output fjr_pkg::out_item_t   res_o
);

  fjr_pkg::phase_e     phase_q, phase_d;
  logic [15:0]         ticks_q, ticks_d;
  fjr_pkg::fire_mode_e fire_q, fire_d;
  fjr_pkg::drive_e     drive_q, drive_d;
  logic [31:0]         angle_q, angle_d;
  logic [31:0]         speed_q, speed_d;
  logic [7:0]          rate_q, rate_d;

  fjr_pkg::fire_mode_e fm_eff;
  logic [17:0]         heat_rem;
  logic                heat_ok;
  logic [15:0]         tq_abs;
  logic [16:0]         sp_abs;
  logic                stall;
  logic [15:0]         ticks_inc;
  logic signed [40:0]  prod;
  logic [31:0]         speed_sat;
  logic                clr;

  // Heat margin, stall test and tick count
  always_comb begin
    fm_eff    = item_i.mode_write ? fjr_pkg::fire_mode_e'(item_i.mode_value) : fire_q;
    heat_rem  = {2'b00, item_i.heat_limit} - {2'b00, item_i.heat_now};
    heat_ok   = $signed(heat_rem) >= $signed({2'b00, cfg_i.heat_per_shot});
    tq_abs    = item_i.measured_torque[15] ? (~item_i.measured_torque + 16'd1)
                                           : item_i.measured_torque;
    sp_abs    = item_i.measured_speed[16] ? (~item_i.measured_speed + 17'd1)
                                          : item_i.measured_speed;
    stall     = (tq_abs >= {1'b0, cfg_i.torque_threshold}) &&
                (sp_abs <= {1'b0, cfg_i.speed_threshold});
    ticks_inc = (ticks_q == fjr_pkg::TicksMax) ? ticks_q : ticks_q + 16'd1;
  end

  // Auto feed speed: step times rate, clamped to 32 bit signed
  always_comb begin
    prod = $signed(cfg_i.bullet_step) * $signed({1'b0, cfg_i.auto_rate});
    if ((&prod[40:31]) || !(|prod[40:31])) begin
      speed_sat = prod[31:0];
    end else if (prod[40]) begin
      speed_sat = 32'h8000_0000;
    end else begin
      speed_sat = 32'h7FFF_FFFF;
    end
  end

  // Next state and held command
  always_comb begin
    phase_d = phase_q;
    fire_d  = fm_eff;
    drive_d = drive_q;
    angle_d = angle_q;
    speed_d = speed_q;
    rate_d  = rate_q;
    clr     = 1'b0;

    unique case (phase_q)
      fjr_pkg::PH_NORMAL: begin
        if (stall) phase_d = fjr_pkg::PH_SUSPECT;
      end
      fjr_pkg::PH_SUSPECT: begin
        if (!stall) begin
          phase_d = fjr_pkg::PH_NORMAL;
        end else if (ticks_inc >= cfg_i.suspect_ticks) begin
          phase_d = fjr_pkg::PH_CONFIRM;
        end
      end
      fjr_pkg::PH_CONFIRM: begin
        angle_d = item_i.measured_angle - cfg_i.backoff_step;
        drive_d = fjr_pkg::DRV_ANGLE;
        phase_d = fjr_pkg::PH_RECOVER;
      end
      fjr_pkg::PH_RECOVER: begin
        if (ticks_inc >= cfg_i.recover_ticks) phase_d = fjr_pkg::PH_NORMAL;
      end
      default: phase_d = phase_q;
    endcase

    // every phase change restarts the count
    ticks_d = (phase_d != phase_q) ? 16'd0 : ticks_inc;

    // fire mode only drives the feeder outside a jam
    if (phase_d == fjr_pkg::PH_NORMAL || phase_d == fjr_pkg::PH_SUSPECT) begin
      case (fm_eff)
        fjr_pkg::FM_DISABLE: begin
          rate_d  = 8'd0;
          drive_d = fjr_pkg::DRV_OFF;
          clr     = 1'b1;
        end
        fjr_pkg::FM_CEASE: begin
          rate_d  = 8'd0;
          drive_d = fjr_pkg::DRV_ANGLE;
        end
        fjr_pkg::FM_SINGLE: begin
          angle_d = item_i.measured_angle + cfg_i.bullet_step;
          drive_d = fjr_pkg::DRV_ANGLE;
          fire_d  = fjr_pkg::FM_CEASE;
        end
        default: begin
          if (heat_ok) begin
            rate_d  = cfg_i.auto_rate;
            drive_d = fjr_pkg::DRV_SPEED;
            speed_d = speed_sat;
          end else begin
            rate_d  = 8'd0;
            angle_d = item_i.measured_angle;
            drive_d = fjr_pkg::DRV_ANGLE;
          end
        end
      endcase
    end
  end

  // State registers advance once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fjr_pkg::PH_NORMAL;
      ticks_q <= 16'd0;
      fire_q  <= fjr_pkg::FM_CEASE;
      drive_q <= fjr_pkg::DRV_ANGLE;
      angle_q <= 32'd0;
      speed_q <= 32'd0;
      rate_q  <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      fire_q  <= fire_d;
      drive_q <= drive_d;
      angle_q <= angle_d;
      speed_q <= speed_d;
      rate_q  <= rate_d;
    end
  end

  // Result word for this tick
  always_comb begin
    res_o.drive_mode        = drive_d;
    res_o.target_angle      = angle_d;
    res_o.target_speed      = speed_d;
    res_o.shot_rate_now     = rate_d;
    res_o.jam_state         = phase_d;
    res_o.heat_ok           = heat_ok;
    res_o.clear_integrators = clr;
  end

endmodule

>>> tb/sv/feeder_jam_recovery_controller_checker.sv
// Command checker: watches the feeder controller streams, predicts each command word and compares.
`timescale 1ns / 1ps

module fjr_command_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [fjr_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [fjr_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [fjr_pkg::CfgAddrW-1:0]  cfg_index_i,
  input  logic [fjr_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                            mismatch_count_o,
  output int                            pending_o,
  output int                            words_checked_o
);

  localparam logic signed [40:0] SpeedMax = 41'sd2147483647;
  localparam logic signed [40:0] SpeedMin = -41'sd2147483648;

  // Shadow registers and controller state
  fjr_pkg::cfg_t        regs;
  fjr_pkg::phase_e      jam;
  logic [15:0]          ticks;
  fjr_pkg::fire_mode_e  fmode;
  fjr_pkg::drive_e      cmd_kind;
  logic [31:0]          cmd_angle;
  logic [31:0]          cmd_speed;
  logic [7:0]           cmd_rate;

  fjr_pkg::out_item_t   expected_cmds[$];

  // One control tick: advance the jam machine, apply the fire mode, queue the command
  task automatic predict_command(input logic [fjr_pkg::InDataW-1:0] w);
    logic signed [15:0] torque;
    logic signed [16:0] speed;
    logic [31:0]        angle;
    logic [15:0]        hlim;
    logic [15:0]        hnow;
    int                 tmag;
    int                 smag;
    int                 margin;
    bit                 ok;
    bit                 stall;
    bit                 clr;
    logic signed [40:0] prod;
    fjr_pkg::out_item_t cmd;
    torque = w[15:0];
    speed  = w[32:16];
    angle  = w[64:33];
    hlim   = w[80:65];
    hnow   = w[96:81];
    clr    = 1'b0;
    if (w[97]) fmode = fjr_pkg::fire_mode_e'(w[99:98]);

    // margin may go negative when heat is over the limit
    margin = int'(hlim) - int'(hnow);
    ok = margin >= int'(regs.heat_per_shot);

    tmag = torque;
    if (tmag < 0) tmag = -tmag;
    smag = speed;
    if (smag < 0) smag = -smag;
    stall = (tmag >= int'(regs.torque_threshold)) && (smag <= int'(regs.speed_threshold));

    if (ticks != fjr_pkg::TicksMax) ticks = ticks + 16'd1;

    case (jam)
      fjr_pkg::PH_NORMAL: begin
        if (stall) begin
          jam = fjr_pkg::PH_SUSPECT;
          ticks = '0;
        end
      end
      fjr_pkg::PH_SUSPECT: begin
        if (!stall) begin
          jam = fjr_pkg::PH_NORMAL;
          ticks = '0;
        end else if (ticks >= regs.suspect_ticks) begin
          jam = fjr_pkg::PH_CONFIRM;
          ticks = '0;
        end
      end
      fjr_pkg::PH_CONFIRM: begin
        // back the feeder off
        cmd_angle = angle - regs.backoff_step;
        cmd_kind = fjr_pkg::DRV_ANGLE;
        jam = fjr_pkg::PH_RECOVER;
        ticks = '0;
      end
      default: begin
        if (ticks >= regs.recover_ticks) begin
          jam = fjr_pkg::PH_NORMAL;
          ticks = '0;
        end
      end
    endcase

    // fire mode only acts while no jam is being handled
    if (jam == fjr_pkg::PH_NORMAL || jam == fjr_pkg::PH_SUSPECT) begin
      case (fmode)
        fjr_pkg::FM_DISABLE: begin
          cmd_rate = '0;
          cmd_kind = fjr_pkg::DRV_OFF;
          clr = 1'b1;
        end
        fjr_pkg::FM_CEASE: begin
          cmd_rate = '0;
          cmd_kind = fjr_pkg::DRV_ANGLE;
        end
        fjr_pkg::FM_SINGLE: begin
          cmd_angle = angle + regs.bullet_step;
          cmd_kind = fjr_pkg::DRV_ANGLE;
          fmode = fjr_pkg::FM_CEASE;
        end
        default: begin
          if (ok) begin
            prod = regs.bullet_step * $signed({33'd0, regs.auto_rate});
            if (prod > SpeedMax) cmd_speed = 32'h7FFF_FFFF;
            else if (prod < SpeedMin) cmd_speed = 32'h8000_0000;
            else cmd_speed = prod[31:0];
            cmd_rate = regs.auto_rate;
            cmd_kind = fjr_pkg::DRV_SPEED;
          end else begin
            cmd_rate = '0;
            cmd_angle = angle;
            cmd_kind = fjr_pkg::DRV_ANGLE;
          end
        end
      endcase
    end

    cmd.drive_mode        = cmd_kind;
    cmd.target_angle      = cmd_angle;
    cmd.target_speed      = cmd_speed;
    cmd.shot_rate_now     = cmd_rate;
    cmd.jam_state         = jam;
    cmd.heat_ok           = ok;
    cmd.clear_integrators = clr;
    expected_cmds.push_back(cmd);
  endtask

  function automatic fjr_pkg::out_item_t unpack_cmd(logic [fjr_pkg::OutDataW-1:0] d);
    fjr_pkg::out_item_t c;
    c.drive_mode        = fjr_pkg::drive_e'(d[1:0]);
    c.target_angle      = d[33:2];
    c.target_speed      = d[65:34];
    c.shot_rate_now     = d[73:66];
    c.jam_state         = fjr_pkg::phase_e'(d[75:74]);
    c.heat_ok           = d[76];
    c.clear_integrators = d[77];
    return c;
  endfunction

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] g);
    if (e !== g) begin
      mismatch_count_o++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, g);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fjr_pkg::out_item_t e;
    fjr_pkg::out_item_t g;
    if (!rst_ni) begin
      regs      = '0;
      jam       = fjr_pkg::PH_NORMAL;
      ticks     = '0;
      fmode     = fjr_pkg::FM_CEASE;
      cmd_kind  = fjr_pkg::DRV_ANGLE;
      cmd_angle = '0;
      cmd_speed = '0;
      cmd_rate  = '0;
      expected_cmds.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      words_checked_o  = 0;
    end else begin
      // register write
      if (cfg_valid_i && cfg_ready_o) begin
        case (fjr_pkg::cfg_addr_e'(cfg_index_i))
          fjr_pkg::REG_TORQUE_TH: regs.torque_threshold = cfg_data_i[14:0];
          fjr_pkg::REG_SPEED_TH:  regs.speed_threshold  = cfg_data_i[15:0];
          fjr_pkg::REG_SUSPECT:   regs.suspect_ticks    = cfg_data_i[15:0];
          fjr_pkg::REG_RECOVER:   regs.recover_ticks    = cfg_data_i[15:0];
          fjr_pkg::REG_BACKOFF:   regs.backoff_step     = cfg_data_i;
          fjr_pkg::REG_BULLET:    regs.bullet_step      = cfg_data_i;
          fjr_pkg::REG_HEAT_SHOT: regs.heat_per_shot    = cfg_data_i[15:0];
          fjr_pkg::REG_AUTO_RATE: regs.auto_rate        = cfg_data_i[7:0];
          default: ;
        endcase
      end
      // command word out
      if (m_axis_tvalid && m_axis_tready) begin
        words_checked_o++;
        if (expected_cmds.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: command word with nothing expected, expected none, actual %0h",
                   $time, m_axis_tdata);
        end else begin
          e = expected_cmds.pop_front();
          g = unpack_cmd(m_axis_tdata);
          check_field("drive_mode", 32'(e.drive_mode), 32'(g.drive_mode));
          check_field("target_angle", e.target_angle, g.target_angle);
          check_field("target_speed", e.target_speed, g.target_speed);
          check_field("shot_rate_now", 32'(e.shot_rate_now), 32'(g.shot_rate_now));
          check_field("jam_state", 32'(e.jam_state), 32'(g.jam_state));
          check_field("heat_ok", 32'(e.heat_ok), 32'(g.heat_ok));
          check_field("clear_integrators", 32'(e.clear_integrators),
                      32'(g.clear_integrators));
        end
      end
      // tick word in
      if (s_axis_tvalid && s_axis_tready) predict_command(s_axis_tdata);
      pending_o = expected_cmds.size();
    end
  end

endmodule

>>> tb/sv/feeder_jam_recovery_controller_test.sv
// Testbench top: clock, reset, tick and register stimulus, and the verdict.
`timescale 1ns / 1ps

module feeder_jam_recovery_controller_test;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [fjr_pkg::InDataW-1:0]   s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [fjr_pkg::OutDataW-1:0]  m_axis_tdata;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [fjr_pkg::CfgAddrW-1:0]  cfg_index_i = '0;
  logic [fjr_pkg::CfgDataW-1:0]  cfg_data_i = '0;

  int mismatches;
  int pending;
  int words_checked;

  fjr_pkg::cfg_t cur_cfg;
  int   src_gap_pct = 0;
  int   snk_gap_pct = 0;
  int   snk_hold = 0;
  int   n_ticks = 0;
  int   n_settings = 0;

  feeder_jam_recovery_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  fjr_command_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .words_checked_o  (words_checked)
  );

  always #2 clk_i = ~clk_i;

  // gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (snk_hold > 0) begin
      snk_hold <= snk_hold - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < snk_gap_pct) begin
      snk_hold <= pick_gap() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // pack one tick word, torque in the lowest bits
  function automatic logic [fjr_pkg::InDataW-1:0] make_tick(
      int torque, int speed, logic [31:0] angle, logic [15:0] hlim, logic [15:0] hnow,
      logic mw, fjr_pkg::fire_mode_e mv);
    logic [fjr_pkg::InDataW-1:0] w;
    logic [31:0]                 t;
    logic [31:0]                 s;
    t = torque;
    s = speed;
    w = '0;
    w[15:0]  = t[15:0];
    w[32:16] = s[16:0];
    w[64:33] = angle;
    w[80:65] = hlim;
    w[96:81] = hnow;
    w[97]    = mw;
    w[99:98] = mv;
    return w;
  endfunction

  task automatic send_tick(input logic [fjr_pkg::InDataW-1:0] w);
    if ($urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    n_ticks++;
  endtask

  // drop valid and let every command word drain
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input fjr_pkg::cfg_addr_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_settings(input fjr_pkg::cfg_t c);
    write_reg(fjr_pkg::REG_TORQUE_TH, 32'(c.torque_threshold));
    write_reg(fjr_pkg::REG_SPEED_TH, 32'(c.speed_threshold));
    write_reg(fjr_pkg::REG_SUSPECT, 32'(c.suspect_ticks));
    write_reg(fjr_pkg::REG_RECOVER, 32'(c.recover_ticks));
    write_reg(fjr_pkg::REG_BACKOFF, c.backoff_step);
    write_reg(fjr_pkg::REG_BULLET, c.bullet_step);
    write_reg(fjr_pkg::REG_HEAT_SHOT, 32'(c.heat_per_shot));
    write_reg(fjr_pkg::REG_AUTO_RATE, 32'(c.auto_rate));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    cur_cfg = c;
    n_settings++;
  endtask

  function automatic fjr_pkg::cfg_t random_settings();
    fjr_pkg::cfg_t c;
    c.torque_threshold = ($urandom_range(0, 7) == 0) ? 15'($urandom)
                                                      : 15'($urandom_range(0, 4000));
    c.speed_threshold  = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 3000));
    c.suspect_ticks    = 16'($urandom_range(0, 6));
    c.recover_ticks    = 16'($urandom_range(0, 6));
    c.backoff_step     = $urandom;
    c.bullet_step      = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1 << 20);
    c.heat_per_shot    = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 2000));
    c.auto_rate        = 8'($urandom);
    return c;
  endfunction

  function automatic fjr_pkg::fire_mode_e pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return fjr_pkg::FM_DISABLE;
    if (r < 3) return fjr_pkg::FM_CEASE;
    if (r < 6) return fjr_pkg::FM_SINGLE;
    return fjr_pkg::FM_AUTO;
  endfunction

  // tick with torque and speed placed inside or outside the stall window
  function automatic logic [fjr_pkg::InDataW-1:0] shaped_tick(bit want_stall);
    int          tmag;
    int          smag;
    int          torque;
    int          speed;
    logic [15:0] hlim;
    logic [15:0] hnow;
    tmag = $urandom_range(0, 32767);
    smag = $urandom_range(0, 65535);
    if (want_stall) begin
      tmag = ($urandom_range(0, 15) == 0) ? 32768 :
             $urandom_range(int'(cur_cfg.torque_threshold), 32767);
      smag = $urandom_range(0, int'(cur_cfg.speed_threshold));
    end else if (cur_cfg.torque_threshold != 0 && $urandom_range(0, 1) == 0) begin
      tmag = $urandom_range(0, int'(cur_cfg.torque_threshold) - 1);
    end else begin
      smag = $urandom_range(int'(cur_cfg.speed_threshold) + 1, 65536);
    end
    torque = (tmag == 32768 || $urandom_range(0, 1) == 0) ? -tmag : tmag;
    speed  = (smag == 65536 || $urandom_range(0, 1) == 0) ? -smag : smag;
    hlim = 16'($urandom);
    hnow = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, int'(hlim))) : 16'($urandom);
    return make_tick(torque, speed, $urandom, hlim, hnow, $urandom_range(0, 3) == 0,
                     pick_mode());
  endfunction

  function automatic logic [fjr_pkg::InDataW-1:0] noise_tick();
    return make_tick($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                     1'($urandom), fjr_pkg::fire_mode_e'($urandom_range(0, 3)));
  endfunction

  initial begin
    fjr_pkg::cfg_t c;
    int   burst_left;
    bit   burst_stall;
    int   phase_src;
    int   phase_snk;
    cur_cfg = '0;
    burst_left = 0;
    burst_stall = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: registers at reset, all zero
    send_tick(make_tick(0, 0, 32'h0, 16'h0, 16'h0, 1'b0, fjr_pkg::FM_DISABLE));
    send_tick(make_tick(-32768, -65536, 32'h8000_0000, 16'hFFFF, 16'h0, 1'b1,
                        fjr_pkg::FM_AUTO));
    send_tick(make_tick(32767, 65535, 32'h7FFF_FFFF, 16'h0, 16'hFFFF, 1'b1,
                        fjr_pkg::FM_SINGLE));
    drain();

    // directed: short suspect window, positive saturation of auto speed
    c.torque_threshold = 15'd1000;
    c.speed_threshold  = 16'd200;
    c.suspect_ticks    = 16'd2;
    c.recover_ticks    = 16'd0;
    c.backoff_step     = 32'h0001_0000;
    c.bullet_step      = 32'h7FFF_FFFF;
    c.heat_per_shot    = 16'd100;
    c.auto_rate        = 8'd255;
    load_settings(c);
    send_tick(make_tick(0, 5000, 32'h0000_1234, 16'd1000, 16'd0, 1'b1, fjr_pkg::FM_DISABLE));
    send_tick(make_tick(0, 5000, 32'h0000_1234, 16'd1000, 16'd0, 1'b1, fjr_pkg::FM_CEASE));
    send_tick(make_tick(0, 5000, 32'h7FFF_0000, 16'd1000, 16'd0, 1'b1, fjr_pkg::FM_SINGLE));
    // single shot falls back to ceasefire
    send_tick(make_tick(0, 5000, 32'h0000_0100, 16'd1000, 16'd0, 1'b0, fjr_pkg::FM_DISABLE));
    send_tick(make_tick(999, 201, 32'h0000_0200, 16'd1000, 16'd0, 1'b1, fjr_pkg::FM_AUTO));
    // heat over the limit, then margin exactly one shot
    send_tick(make_tick(0, 5000, 32'hABCD_0000, 16'd100, 16'd200, 1'b0, fjr_pkg::FM_DISABLE));
    send_tick(make_tick(0, 5000, 32'h1111_0000, 16'd300, 16'd200, 1'b0, fjr_pkg::FM_DISABLE));
    // stall through suspect into confirm, mode change during recover
    send_tick(make_tick(32767, 0, 32'h0001_0000, 16'd300, 16'd0, 1'b0, fjr_pkg::FM_DISABLE));
    send_tick(make_tick(-1000, -200, 32'h0002_0000, 16'd300, 16'd0, 1'b0,
                        fjr_pkg::FM_DISABLE));
    send_tick(make_tick(1000, 200, 32'h0003_0000, 16'd300, 16'd0, 1'b0, fjr_pkg::FM_DISABLE));
    send_tick(make_tick(1000, 200, 32'h8000_0000, 16'd300, 16'd0, 1'b1, fjr_pkg::FM_SINGLE));
    send_tick(make_tick(0, 5000, 32'h0005_0000, 16'd300, 16'd0, 1'b0, fjr_pkg::FM_DISABLE));
    send_tick(make_tick(0, 5000, 32'h0006_0000, 16'd300, 16'd0, 1'b0, fjr_pkg::FM_DISABLE));
    // suspect left again when the stall clears
    send_tick(make_tick(2000, 0, 32'h0007_0000, 16'd300, 16'd0, 1'b1, fjr_pkg::FM_AUTO));
    send_tick(make_tick(2000, 201, 32'h0008_0000, 16'd300, 16'd0, 1'b0, fjr_pkg::FM_DISABLE));
    drain();

    // directed: top thresholds, negative saturation, zero suspect window
    c.torque_threshold = 15'h7FFF;
    c.speed_threshold  = 16'hFFFF;
    c.suspect_ticks    = 16'd0;
    c.recover_ticks    = 16'd1;
    c.backoff_step     = 32'h8000_0000;
    c.bullet_step      = 32'h8000_0000;
    c.heat_per_shot    = 16'hFFFF;
    c.auto_rate        = 8'd255;
    load_settings(c);
    send_tick(make_tick(0, 0, 32'h0, 16'hFFFF, 16'h0, 1'b1, fjr_pkg::FM_AUTO));
    send_tick(make_tick(-32768, 65535, 32'h1234_5678, 16'hFFFF, 16'h0, 1'b0,
                        fjr_pkg::FM_DISABLE));
    send_tick(make_tick(32767, -65535, 32'h0, 16'hFFFF, 16'h1, 1'b0, fjr_pkg::FM_DISABLE));
    send_tick(make_tick(-32768, -65536, 32'h7FFF_FFFF, 16'hFFFF, 16'h0, 1'b0,
                        fjr_pkg::FM_DISABLE));
    send_tick(make_tick(-32768, -65536, 32'h0, 16'hFFFF, 16'h0, 1'b0, fjr_pkg::FM_DISABLE));
    send_tick(make_tick(-32768, -65536, 32'h0, 16'hFFFF, 16'h0, 1'b0, fjr_pkg::FM_DISABLE));
    drain();

    // random phases with varied settings, first all-max then all-zero
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) c = '1;
      else if (ph == 1) c = '0;
      else c = random_settings();
      load_settings(c);
      phase_src = (ph == 2) ? 0 : $urandom_range(5, 40);
      phase_snk = (ph == 2) ? 0 : $urandom_range(5, 40);
      for (int k = 0; k < 200; k++) begin
        // now and then a stretch with no idling
        if (k % 40 == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            src_gap_pct = 0;
            snk_gap_pct = 0;
          end else begin
            src_gap_pct = phase_src;
            snk_gap_pct = phase_snk;
          end
        end
        if (burst_left == 0) begin
          burst_stall = $urandom_range(0, 9) < 6;
          burst_left = burst_stall ? $urandom_range(1, 20) : $urandom_range(1, 6);
        end
        burst_left--;
        if ($urandom_range(0, 99) < 15) send_tick(noise_tick());
        else send_tick(shaped_tick(burst_stall));
      end
      drain();
    end
    repeat (8) @(posedge clk_i);

    $display("run covered %0d ticks over %0d register settings, from all-zero to all-max,",
             n_ticks, n_settings);
    $display("with stall bursts and random idling on both streams; %0d words compared",
             words_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("feeder_jam_recovery_controller_test: clean");
    end else begin
      $display("feeder_jam_recovery_controller_test: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("timeout with %0d command words outstanding", pending);
    $display("feeder_jam_recovery_controller_test: errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/fjr_pkg.sv
rtl/fjr_cfg_regs.sv
rtl/fjr_core.sv
rtl/feeder_jam_recovery_controller.sv
tb/sv/feeder_jam_recovery_controller_checker.sv
tb/sv/feeder_jam_recovery_controller_test.sv
